// ===== rtl/cau_pkg.sv =====
// Shared types and constants of the complex arithmetic unit.
// Used by every module under rtl; depends on nothing.
package cau_pkg;

  localparam int PART_W = 16;
  localparam int FRAC_W = 8;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;
  localparam int MAG_W  = 2 * PART_W;
  localparam int SUM_W  = 2 * PART_W + 1;
  localparam int DIV_W  = MAG_W + PART_W + 1;
  localparam int NSTG   = PART_W + 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int IN_BITS  = MODE_W + 4 * PART_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 * PART_W + STAT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam int AR_LSB = MODE_W;
  localparam int AI_LSB = MODE_W + PART_W;
  localparam int BR_LSB = MODE_W + 2 * PART_W;
  localparam int BI_LSB = MODE_W + 3 * PART_W;

  localparam logic [MAG_W-1:0] PART_LIM = MAG_W'(1) << (PART_W - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_MUL   = 3'd2,
    MODE_DIV   = 3'd3,
    MODE_CONJ  = 3'd4,
    MODE_NEG   = 3'd5,
    MODE_MODSQ = 3'd6
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_DIV    = 2'd1,
    KIND_DIVZ   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic             neg_r;
    logic             neg_i;
    logic [MAG_W-1:0] mag_r;
    logic [MAG_W-1:0] mag_i;
    logic [MAG_W-1:0] den;
  } entry_t;

endpackage

// ===== rtl/cau_front.sv =====
// Front end: accepts items, forms the operand products and classifies each item.
// Depends on cau_pkg; feeds cau_fifo.
module cau_front import cau_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [IN_W-1:0]   in_data_i,
  input  logic              full_i,
  output logic              push_o,
  output entry_t            entry_o
);

  logic                     a_valid_q, b_valid_q, en;
  logic [MODE_W-1:0]        a_mode_q, b_mode_q;
  logic signed [PART_W-1:0] ar_q, ai_q, br_q, bi_q;
  logic signed [PART_W-1:0] b_ar_q, b_ai_q, b_br_q, b_bi_q;
  logic signed [PART_W-1:0] sq0, sq1;
  logic signed [MAG_W-1:0]  p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [SUM_W-1:0]  x_r, x_i;
  logic [MAG_W-1:0]         m_r, m_i;
  logic                     n_r, n_i;

  assign en         = !b_valid_q || !full_i;
  assign in_ready_o = en;
  assign push_o     = b_valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  assign sq0 = (mode_e'(a_mode_q) == MODE_MODSQ) ? ar_q : br_q;
  assign sq1 = (mode_e'(a_mode_q) == MODE_MODSQ) ? ai_q : bi_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mode_q <= in_data_i[MODE_W-1:0];
      ar_q     <= in_data_i[AR_LSB +: PART_W];
      ai_q     <= in_data_i[AI_LSB +: PART_W];
      br_q     <= in_data_i[BR_LSB +: PART_W];
      bi_q     <= in_data_i[BI_LSB +: PART_W];
      b_mode_q <= a_mode_q;
      b_ar_q   <= ar_q;
      b_ai_q   <= ai_q;
      b_br_q   <= br_q;
      b_bi_q   <= bi_q;
      p0_q     <= ar_q * br_q;
      p1_q     <= ai_q * bi_q;
      p2_q     <= ar_q * bi_q;
      p3_q     <= ai_q * br_q;
      p4_q     <= sq0 * sq0;
      p5_q     <= sq1 * sq1;
    end
  end

  always_comb begin
    entry_o      = '0;
    entry_o.kind = KIND_DIRECT;
    x_r = '0;
    x_i = '0;
    unique case (b_mode_q)
      MODE_ADD: begin
        x_r = SUM_W'(b_ar_q) + SUM_W'(b_br_q);
        x_i = SUM_W'(b_ai_q) + SUM_W'(b_bi_q);
      end
      MODE_SUB: begin
        x_r = SUM_W'(b_ar_q) - SUM_W'(b_br_q);
        x_i = SUM_W'(b_ai_q) - SUM_W'(b_bi_q);
      end
      MODE_MUL: begin
        x_r = SUM_W'(p0_q) - SUM_W'(p1_q);
        x_i = SUM_W'(p2_q) + SUM_W'(p3_q);
      end
      MODE_DIV: begin
        x_r = SUM_W'(p0_q) + SUM_W'(p1_q);
        x_i = SUM_W'(p3_q) - SUM_W'(p2_q);
      end
      MODE_CONJ: begin
        x_r = SUM_W'(b_ar_q);
        x_i = -SUM_W'(b_ai_q);
      end
      MODE_NEG: begin
        x_r = -SUM_W'(b_ar_q);
        x_i = -SUM_W'(b_ai_q);
      end
      MODE_MODSQ: begin
        x_r = SUM_W'(p4_q) + SUM_W'(p5_q);
      end
      default: begin
        x_r = '0;
      end
    endcase
    n_r = x_r[SUM_W-1];
    n_i = x_i[SUM_W-1];
    m_r = n_r ? MAG_W'(-x_r) : MAG_W'(x_r);
    m_i = n_i ? MAG_W'(-x_i) : MAG_W'(x_i);
    entry_o.neg_r = n_r;
    entry_o.neg_i = n_i;
    entry_o.mag_r = m_r;
    entry_o.mag_i = m_i;
    if (b_mode_q == MODE_MUL) begin
      entry_o.mag_r = m_r >> FRAC_W;
      entry_o.mag_i = m_i >> FRAC_W;
    end else if (b_mode_q == MODE_MODSQ) begin
      entry_o.mag_r = m_r >> FRAC_W;
    end else if (b_mode_q == MODE_DIV) begin
      entry_o.den  = MAG_W'(SUM_W'(p4_q) + SUM_W'(p5_q));
      entry_o.kind = (entry_o.den == '0) ? KIND_DIVZ : KIND_DIV;
    end
  end

endmodule

// ===== rtl/cau_fifo.sv =====
// Short queue between front and back end.
// Depends on cau_pkg for the entry type and depth.
module cau_fifo import cau_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wdata_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t rdata_o,
  output logic   empty_o
);

  entry_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

endmodule

// ===== rtl/cau_back.sv =====
// Back end: pipelined restoring divider, then saturation and the output register.
// Depends on cau_pkg; drains cau_fifo.
module cau_back import cau_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  entry_t           entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] out_data_o
);

  typedef struct packed {
    kind_e            kind;
    logic             neg_r;
    logic             neg_i;
    logic [MAG_W-1:0] mag_r;
    logic [MAG_W-1:0] mag_i;
    logic [MAG_W-1:0] den;
    logic [DIV_W-1:0] rem_r;
    logic [DIV_W-1:0] rem_i;
    logic [PART_W:0]  q_r;
    logic [PART_W:0]  q_i;
    logic             ovf_r;
    logic             ovf_i;
  } stage_t;

  stage_t              stg_q [NSTG];
  stage_t              stg_d [NSTG];
  logic [NSTG-1:0]     vld_q;
  logic                en, out_valid_q;
  logic [PART_W-1:0]   res_r_q, res_i_q;
  status_e             status_q;
  stage_t              last;
  logic [MAG_W-1:0]    fm_r, fm_i;
  logic [PART_W:0]     pk_r, pk_i;

  function automatic logic [PART_W:0] sat_part(input logic neg, input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] neg_mag;
    neg_mag = -mag;
    if (neg && mag != '0) begin
      if (mag > PART_LIM) return {1'b1, 1'b1, {(PART_W-1){1'b0}}};
      return {1'b0, neg_mag[PART_W-1:0]};
    end
    if (mag > PART_LIM - 1'b1) return {1'b1, 1'b0, {(PART_W-1){1'b1}}};
    return {1'b0, mag[PART_W-1:0]};
  endfunction

  assign en          = !out_valid_q || out_ready_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = OUT_W'({status_q, res_i_q, res_r_q});

  always_comb begin
    logic [DIV_W-1:0] t;
    stg_d[0]       = '0;
    stg_d[0].kind  = entry_i.kind;
    stg_d[0].neg_r = entry_i.neg_r;
    stg_d[0].neg_i = entry_i.neg_i;
    stg_d[0].mag_r = entry_i.mag_r;
    stg_d[0].mag_i = entry_i.mag_i;
    stg_d[0].den   = entry_i.den;
    stg_d[0].rem_r = DIV_W'(entry_i.mag_r) << FRAC_W;
    stg_d[0].rem_i = DIV_W'(entry_i.mag_i) << FRAC_W;
    stg_d[0].ovf_r = (stg_d[0].rem_r >> (PART_W + 1)) >= DIV_W'(entry_i.den);
    stg_d[0].ovf_i = (stg_d[0].rem_i >> (PART_W + 1)) >= DIV_W'(entry_i.den);
    for (int s = 1; s < NSTG; s++) begin
      stg_d[s] = stg_q[s-1];
      t = DIV_W'(stg_q[s-1].den) << (NSTG - 1 - s);
      if (stg_q[s-1].rem_r >= t) begin
        stg_d[s].rem_r = stg_q[s-1].rem_r - t;
        stg_d[s].q_r[NSTG-1-s] = 1'b1;
      end
      if (stg_q[s-1].rem_i >= t) begin
        stg_d[s].rem_i = stg_q[s-1].rem_i - t;
        stg_d[s].q_i[NSTG-1-s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NSTG-2:0], pop_o};
      out_valid_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NSTG; s++) stg_q[s] <= stg_d[s];
    end
  end

  assign last = stg_q[NSTG-1];

  always_comb begin
    fm_r = last.mag_r;
    fm_i = last.mag_i;
    if (last.kind == KIND_DIV) begin
      fm_r = last.ovf_r ? PART_LIM + 1'b1 : MAG_W'(last.q_r);
      fm_i = last.ovf_i ? PART_LIM + 1'b1 : MAG_W'(last.q_i);
    end
    pk_r = sat_part(last.neg_r, fm_r);
    pk_i = sat_part(last.neg_i, fm_i);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (last.kind == KIND_DIVZ) begin
        res_r_q  <= '0;
        res_i_q  <= '0;
        status_q <= ST_DIVZ;
      end else begin
        res_r_q  <= pk_r[PART_W-1:0];
        res_i_q  <= pk_i[PART_W-1:0];
        status_q <= (pk_r[PART_W] || pk_i[PART_W]) ? ST_SAT : ST_OK;
      end
    end
  end

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: front end, queue and back end.
// Depends on cau_pkg, cau_front, cau_fifo and cau_back.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  mode, a_real, a_imag, b_real, b_imag
//   m_axis    out  m_axis_tvalid/m_axis_tready  res_real, res_imag, status
//
// One item per cycle sustained while m_axis_tready stays high; an item passes the front
// registers, the queue, PART_W+2 divider stages and the output register.
// The divider, an overflow stage then one quotient bit per stage, sets the latency.
// Reset empties all stages and the queue; the back end stalls as a whole on
// m_axis_tready and the four-entry queue lets the front keep accepting.
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // mode, a_real, a_imag, b_real, b_imag
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata   // res_real, res_imag, status
);

  logic   push, full, pop, empty;
  entry_t wentry, rentry;

  cau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (wentry)
  );

  cau_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rentry),
    .empty_o (empty)
  );

  cau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (rentry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for complex_arithmetic_unit: random and directed items on
// the input stream, an in-bench predictor of every mode, scoreboard on output.
// Depends on cau_pkg and the RTL under rtl.
module tb_top import cau_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [PART_W-1:0] re;
    logic [PART_W-1:0] im;
    logic [STAT_W-1:0] st;
  } cplx_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  logic [IN_W-1:0] pending_items[$];
  cplx_res_t expected_results[$];
  int n_mismatch = 0;
  int n_checked = 0;
  int n_sent = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_cycles = 0;
  bit hold_req = 1'b0;
  bit drain_req = 1'b0;

  complex_arithmetic_unit u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [PART_W-1:0] clamp_part(longint v, inout bit sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'h7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'h8000;
    end
    return v[PART_W-1:0];
  endfunction

  // truncate toward zero
  function automatic longint shr_trunc(longint v);
    return (v < 0) ? -((-v) >>> FRAC_W) : (v >>> FRAC_W);
  endfunction

  function automatic longint div_trunc(longint n, longint d);
    longint q;
    q = ((n < 0 ? -n : n) << FRAC_W) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic cplx_res_t predict_cplx(logic [IN_W-1:0] d);
    logic [MODE_W-1:0] m;
    longint ar, ai, br, bi, rr, ri, den;
    bit sat;
    cplx_res_t r;
    m = d[MODE_W-1:0];
    ar = longint'($signed(d[AR_LSB +: PART_W]));
    ai = longint'($signed(d[AI_LSB +: PART_W]));
    br = longint'($signed(d[BR_LSB +: PART_W]));
    bi = longint'($signed(d[BI_LSB +: PART_W]));
    rr = 0;
    ri = 0;
    sat = 1'b0;
    r.st = ST_OK;
    case (m)
      MODE_ADD: begin rr = ar + br; ri = ai + bi; end
      MODE_SUB: begin rr = ar - br; ri = ai - bi; end
      MODE_MUL: begin
        rr = shr_trunc(ar * br - ai * bi);
        ri = shr_trunc(ar * bi + ai * br);
      end
      MODE_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.st = ST_DIVZ;
        else begin
          rr = div_trunc(ar * br + ai * bi, den);
          ri = div_trunc(ai * br - ar * bi, den);
        end
      end
      MODE_CONJ: begin rr = ar; ri = -ai; end
      MODE_NEG: begin rr = -ar; ri = -ai; end
      MODE_MODSQ: rr = (ar * ar + ai * ai) >>> FRAC_W;
      default: ;
    endcase
    r.re = clamp_part(rr, sat);
    r.im = clamp_part(ri, sat);
    if (r.st == ST_OK && sat) r.st = ST_SAT;
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_item(logic [MODE_W-1:0] m, logic [PART_W-1:0] ar,
      logic [PART_W-1:0] ai, logic [PART_W-1:0] br, logic [PART_W-1:0] bi);
    logic [IN_W-1:0] d;
    d = '0;
    d[MODE_W-1:0] = m;
    d[AR_LSB +: PART_W] = ar;
    d[AI_LSB +: PART_W] = ai;
    d[BR_LSB +: PART_W] = br;
    d[BI_LSB +: PART_W] = bi;
    return d;
  endfunction

  function automatic logic [PART_W-1:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return PART_W'($signed($urandom_range(0, 1024)) - 512);
      3: return 16'h0000;
      default: return PART_W'($urandom());
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_cplx(s_axis_tdata));
        n_sent <= n_sent + 1;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0 && !drain_req) begin
          s_axis_tdata <= pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && hold_cycles == 0) hold_cycles <= 80;
      else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else if (n_sent % 200 < 60) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cplx_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected item %h", m_axis_tdata);
      end else begin
        e = expected_results.pop_front();
        n_checked++;
        if (m_axis_tdata[PART_W-1:0] !== e.re || m_axis_tdata[PART_W +: PART_W] !== e.im ||
            m_axis_tdata[2*PART_W +: STAT_W] !== e.st) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp re %h im %h st %0d, got re %h im %h st %0d",
                     e.re, e.im, e.st, m_axis_tdata[PART_W-1:0],
                     m_axis_tdata[PART_W +: PART_W], m_axis_tdata[2*PART_W +: STAT_W]);
        end
      end
    end
  end

  initial begin
    logic [PART_W-1:0] ext[6];
    int k;
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'h0100, 16'hff00, 16'h0001};
    for (int m = 0; m < 8; m++)
      pending_items.push_back(pack_item(MODE_W'(m), ext[m % 6], ext[(m + 1) % 6],
                                        ext[(m + 2) % 6], ext[(m + 3) % 6]));
    pending_items.push_back(pack_item(MODE_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000));
    pending_items.push_back(pack_item(MODE_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000));
    pending_items.push_back(pack_item(MODE_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    pending_items.push_back(pack_item(MODE_DIV, 16'hff00, 16'h0080, 16'h0300, 16'hfd00));
    pending_items.push_back(pack_item(MODE_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    pending_items.push_back(pack_item(MODE_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000));
    pending_items.push_back(pack_item(MODE_MODSQ, 16'h8000, 16'h8000, 16'h0000, 16'h0000));
    pending_items.push_back(pack_item(MODE_NEG, 16'h8000, 16'h8000, 16'h0000, 16'h0000));
    pending_items.push_back(pack_item(MODE_CONJ, 16'h1234, 16'h8000, 16'hffff, 16'hffff));
    pending_items.push_back(pack_item(MODE_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff));
    pending_items.push_back(pack_item(MODE_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff));
    for (int i = 0; i < 930; i++) begin
      k = $urandom_range(0, 15);
      pending_items.push_back(pack_item(MODE_W'((k < 3) ? 3 : ((k == 15) ? 7 : k % 7)),
                              rand_part(), rand_part(), rand_part(), rand_part()));
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (n_sent >= 300);
    @(posedge clk_i);
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    wait (n_sent >= 600);
    @(posedge clk_i);
    drain_req <= 1'b1;
    wait (expected_results.size() == 0 && !s_axis_tvalid);
    @(posedge clk_i);
    drain_req <= 1'b0;
    wait (pending_items.size() == 0 && !s_axis_tvalid);
    wait (expected_results.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("%0d items checked over all modes, extremes, zero divisors and stalls",
             n_checked);
    if (n_mismatch == 0 && expected_results.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_fifo.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
tb/tb_top.sv
